@@ rtl/bitmap_frame_allocator_defines.svh @@
// Assertion macros shared by the allocator checker.
// Depends on nothing; included by the checker file.
`ifndef BITMAP_FRAME_ALLOCATOR_DEFINES_SVH
`define BITMAP_FRAME_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, sampled on aclk, off during reset.
`define BFA_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on aclk, off during reset.
`define BFA_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/bfa_pkg.sv @@
// Shared types, codes and helper functions of the bitmap frame allocator.
// No dependencies.
package bfa_pkg;

    localparam int IDX_W  = 21;          // frame index, one past the 32-bit top
    localparam int WIDX_W = IDX_W - 5;   // bitmap word index

    typedef logic [IDX_W-1:0]  fidx_t;
    typedef logic [WIDX_W-1:0] widx_t;

    localparam logic [2:0] OP_CLEAR   = 3'd0;
    localparam logic [2:0] OP_ADD     = 3'd1;
    localparam logic [2:0] OP_RESERVE = 3'd2;
    localparam logic [2:0] OP_ALLOC   = 3'd3;
    localparam logic [2:0] OP_FREE    = 3'd4;

    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_NOT_READY  = 3'd1;
    localparam logic [2:0] ST_NONE_FREE  = 3'd2;
    localparam logic [2:0] ST_MISALIGNED = 3'd3;
    localparam logic [2:0] ST_OUTSIDE    = 3'd4;
    localparam logic [2:0] ST_NOT_ALLOC  = 3'd5;
    localparam logic [2:0] ST_REJECTED   = 3'd6;

    localparam logic [63:0] LOW_LIMIT = 64'h0000_0000_0010_0000;
    localparam logic [63:0] TOP_LIMIT = 64'h0000_0000_FFFF_FFFF;

    typedef struct packed {
        logic load;    // capture an input beat
        logic prep;    // first bounds stage
        logic check;   // decide and set up the walk
        logic sweep;   // write one all-ones word
        logic rd;      // read bitmap word
        logic wr;      // modify and write bitmap word
    } bfa_cmd_t;

    typedef struct packed {
        logic sweep_last;
        logic is_clear;
        logic walk;
        logic last;
    } bfa_sts_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] frame_address;
        logic [15:0] total_frames;
        logic [15:0] used_frames;
        logic [15:0] free_frames;
        logic [31:0] highest_end;
    } bfa_res_t;

    // Bits of word w whose frame index falls in [lo, hi).
    function automatic logic [31:0] span_mask(input widx_t w, input fidx_t lo, input fidx_t hi);
        logic [31:0] ge;
        logic [31:0] lt;
        if (w > lo[IDX_W-1:5]) begin
            ge = '1;
        end else if (w == lo[IDX_W-1:5]) begin
            ge = 32'hFFFF_FFFF << lo[4:0];
        end else begin
            ge = '0;
        end
        if (w < hi[IDX_W-1:5]) begin
            lt = '1;
        end else if (w == hi[IDX_W-1:5]) begin
            lt = ~(32'hFFFF_FFFF << hi[4:0]);
        end else begin
            lt = '0;
        end
        return ge & lt;
    endfunction

    function automatic logic [5:0] popcount32(input logic [31:0] v);
        logic [5:0] c;
        c = '0;
        for (int i = 0; i < 32; i++) begin
            c = c + {5'd0, v[i]};
        end
        return c;
    endfunction

    function automatic logic [4:0] lowest_bit(input logic [31:0] v);
        logic [4:0] b;
        b = '0;
        for (int i = 31; i >= 0; i--) begin
            if (v[i]) begin
                b = 5'(i);
            end
        end
        return b;
    endfunction

    function automatic logic [15:0] sat_add(input logic [15:0] c, input logic [5:0] n);
        logic [16:0] s;
        s = {1'b0, c} + {11'd0, n};
        return s[16] ? 16'hFFFF : s[15:0];
    endfunction

endpackage

@@ rtl/bfa_ctrl.sv @@
// Sequencer of the frame allocator: issues datapath commands per state.
// Depends on bfa_pkg.
module bfa_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic             out_free,
    output logic             out_load,
    input  bfa_pkg::bfa_sts_t sts,
    output bfa_pkg::bfa_cmd_t cmd
);
    import bfa_pkg::*;

    localparam logic [2:0] S_SWEEP = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_PREP  = 3'd2;
    localparam logic [2:0] S_CHECK = 3'd3;
    localparam logic [2:0] S_RD    = 3'd4;
    localparam logic [2:0] S_WR    = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] state_reg, state_next;
    logic       clr_pend_reg, clr_pend_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_SWEEP;
            clr_pend_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_pend_reg <= clr_pend_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        clr_pend_next = clr_pend_reg;
        cmd           = '0;
        s_ready       = 1'b0;
        out_load      = 1'b0;
        case (state_reg)
            S_SWEEP: begin
                cmd.sweep = 1'b1;
                if (sts.sweep_last) begin
                    state_next    = clr_pend_reg ? S_DONE : S_IDLE;
                    clr_pend_next = 1'b0;
                end
            end
            S_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = S_CHECK;
            end
            S_CHECK: begin
                cmd.check = 1'b1;
                if (sts.is_clear) begin
                    state_next    = S_SWEEP;
                    clr_pend_next = 1'b1;
                end else if (sts.walk) begin
                    state_next = S_RD;
                end else begin
                    state_next = S_DONE;
                end
            end
            S_RD: begin
                cmd.rd     = 1'b1;
                state_next = S_WR;
            end
            S_WR: begin
                cmd.wr     = 1'b1;
                state_next = sts.last ? S_DONE : S_RD;
            end
            S_DONE: begin
                // hold until the result register has room
                out_load = out_free;
                if (out_free) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

@@ rtl/bfa_datapath.sv @@
// Datapath of the frame allocator: bitmap RAM, region table, counters.
// Depends on bfa_pkg; driven by bfa_ctrl commands.
module bfa_datapath #(
    parameter int FRAME_COUNT  = 32768,
    parameter int REGION_SLOTS = 8
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [31:0]       cfg_wr_data,
    input  logic [2:0]        s_opcode,
    input  logic [63:0]       s_addr_a,
    input  logic [63:0]       s_addr_b,
    input  bfa_pkg::bfa_cmd_t cmd,
    output bfa_pkg::bfa_sts_t sts,
    output bfa_pkg::bfa_res_t res
);
    import bfa_pkg::*;

    localparam int WORDS = FRAME_COUNT / 32;
    localparam int WA_W  = $clog2(WORDS);
    localparam int HW    = $clog2(FRAME_COUNT);
    localparam int RC_W  = $clog2(REGION_SLOTS + 1);
    localparam fidx_t FC_IDX = fidx_t'(FRAME_COUNT);

    logic [31:0] bitmap_mem [WORDS];
    logic [31:0] rdata_reg;

    logic [2:0]  op_reg;
    logic [63:0] a_reg, b_reg;
    logic [31:0] s_cl_reg, e_cl_reg;
    logic        early_rej_reg;
    fidx_t       rfirst_reg, rlast_reg;
    logic [31:0] kend_reg;

    logic [31:0] rstart_reg [REGION_SLOTS];
    logic [31:0] rend_reg   [REGION_SLOTS];
    logic [RC_W-1:0] rcount_reg;
    logic [15:0] total_reg, used_reg;
    logic [HW-1:0] hint_reg;
    logic [31:0] highest_reg;

    fidx_t       lo_reg, hi_reg;
    logic [WA_W-1:0] word_reg;
    logic [WA_W:0]   visit_reg;
    logic [2:0]  status_reg;
    logic [31:0] faddr_reg;

    // ---- first bounds stage
    logic [64:0] e_sum;
    logic [63:0] e_sat, s_cl, e_cl;
    logic [52:0] rlast_raw;
    fidx_t       rfirst_c, rlast_c;

    always_comb begin
        e_sum     = {1'b0, a_reg} + {1'b0, b_reg};
        e_sat     = e_sum[64] ? '1 : e_sum[63:0];
        s_cl      = (a_reg < LOW_LIMIT) ? LOW_LIMIT : a_reg;
        e_cl      = (e_sat > TOP_LIMIT) ? TOP_LIMIT : e_sat;
        rfirst_c  = ({12'd0, a_reg[63:12]} >= 64'(FRAME_COUNT)) ? FC_IDX
                                                              : a_reg[IDX_W+11:12];
        rlast_raw = {1'b0, b_reg[63:12]} + {52'd0, (b_reg[11:0] != 12'd0)};
        rlast_c   = ({11'd0, rlast_raw} >= 64'(FRAME_COUNT)) ? FC_IDX
                                                             : rlast_raw[IDX_W-1:0];
    end

    // ---- decision stage
    fidx_t rs_idx, req_idx, rs2, re_idx, add_lo, add_hi, free_idx;
    logic  ready, add_rej;

    always_comb begin
        ready    = rcount_reg != '0;
        rs_idx   = {1'b0, s_cl_reg[31:12]} + fidx_t'(s_cl_reg[11:0] != 12'd0);
        req_idx  = {1'b0, kend_reg[31:12]} + fidx_t'(kend_reg[11:0] != 12'd0);
        rs2      = (rs_idx < req_idx) ? req_idx : rs_idx;
        re_idx   = {1'b0, e_cl_reg[31:12]};
        add_rej  = early_rej_reg || (rs2 >= re_idx) || (rcount_reg == RC_W'(REGION_SLOTS));
        add_lo   = (rs2 > FC_IDX) ? FC_IDX : rs2;
        add_hi   = (re_idx > FC_IDX) ? FC_IDX : re_idx;
        free_idx = {1'b0, a_reg[31:12]};
    end

    // ---- word stage
    widx_t       word16;
    fidx_t       hi_m1, alloc_idx, hint_f;
    logic [31:0] regmask, rmask, pass, cand, delta, wdata;
    logic [4:0]  cbit;
    logic        first_visit, last_visit;

    always_comb begin
        word16  = widx_t'(word_reg);
        regmask = '0;
        for (int i = 0; i < REGION_SLOTS; i++) begin
            if (RC_W'(i) < rcount_reg) begin
                regmask = regmask | span_mask(word16, {1'b0, rstart_reg[i][31:12]},
                                              {1'b0, rend_reg[i][31:12]});
            end
        end
        rmask       = span_mask(word16, lo_reg, hi_reg);
        hi_m1       = hi_reg - 1'b1;
        first_visit = visit_reg == '0;
        last_visit  = visit_reg == (WA_W+1)'(WORDS);
        if (first_visit) begin
            pass = 32'hFFFF_FFFF << hint_reg[4:0];
        end else if (last_visit) begin
            pass = ~(32'hFFFF_FFFF << hint_reg[4:0]);
        end else begin
            pass = '1;
        end
        cand      = ~rdata_reg & regmask & pass;
        cbit      = lowest_bit(cand);
        alloc_idx = fidx_t'({word_reg, cbit});
        hint_f    = fidx_t'(hint_reg);
        delta     = '0;
        wdata     = rdata_reg;
        case (op_reg)
            OP_ADD: begin
                delta = rdata_reg & rmask;
                wdata = rdata_reg & ~delta;
            end
            OP_RESERVE: begin
                delta = ~rdata_reg & rmask & regmask;
                wdata = rdata_reg | delta;
            end
            OP_ALLOC: begin
                wdata = rdata_reg | (32'd1 << cbit);
            end
            OP_FREE: begin
                wdata = rdata_reg & ~(32'd1 << lo_reg[4:0]);
            end
            default: begin
                wdata = rdata_reg;
            end
        endcase
    end

    // ---- control status back to the sequencer
    always_comb begin
        sts            = '0;
        sts.sweep_last = word_reg == WA_W'(WORDS - 1);
        sts.is_clear   = op_reg == OP_CLEAR;
        case (op_reg)
            OP_ADD:     sts.walk = !add_rej && (add_lo < add_hi);
            OP_RESERVE: sts.walk = ready && (rfirst_reg < rlast_reg);
            OP_ALLOC:   sts.walk = ready && (used_reg < total_reg);
            OP_FREE:    sts.walk = ready && (a_reg[11:0] == 12'd0)
                                   && (a_reg[63:12] < 52'(FRAME_COUNT));
            default:    sts.walk = 1'b0;
        endcase
        case (op_reg)
            OP_ADD, OP_RESERVE: sts.last = word16 == hi_m1[IDX_W-1:5];
            OP_ALLOC:           sts.last = (cand != '0) || last_visit;
            default:            sts.last = 1'b1;
        endcase
    end

    // ---- bitmap RAM
    logic mem_we;
    logic [31:0] mem_wd;

    always_comb begin
        mem_we = cmd.sweep;
        mem_wd = '1;
        if (cmd.wr) begin
            mem_wd = wdata;
            case (op_reg)
                OP_ADD, OP_RESERVE: mem_we = 1'b1;
                OP_ALLOC:           mem_we = cand != '0;
                OP_FREE:            mem_we = regmask[lo_reg[4:0]] && rdata_reg[lo_reg[4:0]];
                default:            mem_we = 1'b0;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            bitmap_mem[word_reg] <= mem_wd;
        end
        if (cmd.rd) begin
            rdata_reg <= bitmap_mem[word_reg];
        end
    end

    // ---- payload registers
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            a_reg <= s_addr_a;
            b_reg <= s_addr_b;
        end
        if (cmd.prep) begin
            s_cl_reg      <= s_cl[31:0];
            e_cl_reg      <= e_cl[31:0];
            early_rej_reg <= s_cl >= e_cl;
            rfirst_reg    <= rfirst_c;
            rlast_reg     <= rlast_c;
        end
        if (cmd.check && op_reg == OP_ADD && !add_rej) begin
            for (int i = 0; i < REGION_SLOTS; i++) begin
                if (rcount_reg == RC_W'(i)) begin
                    rstart_reg[i] <= {rs2[19:0], 12'd0};
                    rend_reg[i]   <= {re_idx[19:0], 12'd0};
                end
            end
        end
    end

    // ---- control and counter registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            op_reg      <= OP_CLEAR;
            kend_reg    <= '0;
            rcount_reg  <= '0;
            total_reg   <= '0;
            used_reg    <= '0;
            hint_reg    <= '0;
            highest_reg <= '0;
            word_reg    <= '0;
            visit_reg   <= '0;
            lo_reg      <= '0;
            hi_reg      <= '0;
            status_reg  <= ST_OK;
            faddr_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                kend_reg <= cfg_wr_data;
            end
            if (cmd.load) begin
                op_reg <= s_opcode;
            end
            if (cmd.sweep) begin
                word_reg <= sts.sweep_last ? '0 : word_reg + 1'b1;
            end
            if (cmd.check) begin
                faddr_reg  <= '0;
                status_reg <= ST_OK;
                visit_reg  <= '0;
                case (op_reg)
                    OP_CLEAR: begin
                        rcount_reg  <= '0;
                        total_reg   <= '0;
                        used_reg    <= '0;
                        hint_reg    <= '0;
                        highest_reg <= '0;
                        word_reg    <= '0;
                    end
                    OP_ADD: begin
                        if (add_rej) begin
                            status_reg <= ST_REJECTED;
                        end else begin
                            rcount_reg <= rcount_reg + 1'b1;
                            if ({re_idx[19:0], 12'd0} > highest_reg) begin
                                highest_reg <= {re_idx[19:0], 12'd0};
                            end
                            lo_reg   <= add_lo;
                            hi_reg   <= add_hi;
                            word_reg <= add_lo[WA_W+4:5];
                        end
                    end
                    OP_RESERVE: begin
                        if (!ready) begin
                            status_reg <= ST_NOT_READY;
                        end
                        lo_reg   <= rfirst_reg;
                        hi_reg   <= rlast_reg;
                        word_reg <= rfirst_reg[WA_W+4:5];
                    end
                    OP_ALLOC: begin
                        if (!ready) begin
                            status_reg <= ST_NOT_READY;
                        end else if (used_reg >= total_reg) begin
                            status_reg <= ST_NONE_FREE;
                        end
                        word_reg <= WA_W'(hint_reg >> 5);
                    end
                    OP_FREE: begin
                        if (!ready) begin
                            status_reg <= ST_NOT_READY;
                        end else if (a_reg[11:0] != 12'd0) begin
                            status_reg <= ST_MISALIGNED;
                        end else if (a_reg[63:12] >= 52'(FRAME_COUNT)) begin
                            status_reg <= ST_OUTSIDE;
                        end
                        lo_reg   <= free_idx;
                        word_reg <= free_idx[WA_W+4:5];
                    end
                    default: begin
                        status_reg <= ST_OK;
                    end
                endcase
            end
            if (cmd.wr) begin
                case (op_reg)
                    OP_ADD: begin
                        total_reg <= sat_add(total_reg, popcount32(delta));
                        word_reg  <= word_reg + 1'b1;
                    end
                    OP_RESERVE: begin
                        used_reg <= sat_add(used_reg, popcount32(delta));
                        word_reg <= word_reg + 1'b1;
                    end
                    OP_ALLOC: begin
                        if (cand != '0) begin
                            used_reg  <= sat_add(used_reg, 6'd1);
                            faddr_reg <= {alloc_idx[19:0], 12'd0};
                            hint_reg  <= (alloc_idx == FC_IDX - 1'b1) ? '0
                                         : HW'(alloc_idx + 1'b1);
                        end else if (last_visit) begin
                            status_reg <= ST_NONE_FREE;
                        end else begin
                            // advance with wrap
                            word_reg  <= (word_reg == WA_W'(WORDS - 1)) ? '0 : word_reg + 1'b1;
                            visit_reg <= visit_reg + 1'b1;
                        end
                    end
                    OP_FREE: begin
                        if (!regmask[lo_reg[4:0]]) begin
                            status_reg <= ST_OUTSIDE;
                        end else if (!rdata_reg[lo_reg[4:0]]) begin
                            status_reg <= ST_NOT_ALLOC;
                        end else begin
                            if (lo_reg < hint_f) begin
                                hint_reg <= HW'(lo_reg);
                            end
                            if (used_reg != '0) begin
                                used_reg <= used_reg - 1'b1;
                            end
                        end
                    end
                    default: begin
                        status_reg <= status_reg;
                    end
                endcase
            end
        end
    end

    // ---- result view
    always_comb begin
        res.status        = status_reg;
        res.frame_address = faddr_reg;
        res.total_frames  = ready ? total_reg : '0;
        res.used_frames   = ready ? used_reg : '0;
        res.free_frames   = (ready && used_reg < total_reg) ? total_reg - used_reg : '0;
        res.highest_end   = ready ? highest_reg : '0;
    end

endmodule

@@ rtl/bitmap_frame_allocator.sv @@
// Bitmap page-frame allocator, one bit per 4 KiB frame, next-fit allocation.
// Every beat gives one result beat: accept, two decode stages, result load;
// a bitmap walk in between reads each 32-frame word, then modifies and writes
// it, through the single-port bitmap RAM: add and reserve touch the words
// of their range, free touches one word, allocate scans from the hint word
// and stops at the first free frame, at most FRAME_COUNT/32 + 1 words. After
// reset and after a clear the RAM is filled with ones, and meanwhile no beat
// is accepted. A new beat is taken while a finished result still waits on
// the output. Depends on bfa_pkg, bfa_ctrl, bfa_datapath.
module bitmap_frame_allocator #(
    parameter int FRAME_COUNT  = 32768,
    parameter int REGION_SLOTS = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [31:0] cfg_wr_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_opcode,
    input  logic [63:0] s_addr_a,
    input  logic [63:0] s_addr_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_status,
    output logic [31:0] m_frame_address,
    output logic [15:0] m_total_frames,
    output logic [15:0] m_used_frames,
    output logic [15:0] m_free_frames,
    output logic [31:0] m_highest_end
);
    import bfa_pkg::*;

    bfa_cmd_t cmd;
    bfa_sts_t sts;
    bfa_res_t res;
    bfa_res_t out_reg;
    logic     m_valid_reg;
    logic     out_load;

    bfa_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .out_free (!m_valid_reg || m_ready),
        .out_load (out_load),
        .sts      (sts),
        .cmd      (cmd)
    );

    bfa_datapath #(
        .FRAME_COUNT  (FRAME_COUNT),
        .REGION_SLOTS (REGION_SLOTS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_opcode    (s_opcode),
        .s_addr_a    (s_addr_a),
        .s_addr_b    (s_addr_b),
        .cmd         (cmd),
        .sts         (sts),
        .res         (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            out_reg <= res;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_status        = out_reg.status;
    assign m_frame_address = out_reg.frame_address;
    assign m_total_frames  = out_reg.total_frames;
    assign m_used_frames   = out_reg.used_frames;
    assign m_free_frames   = out_reg.free_frames;
    assign m_highest_end   = out_reg.highest_end;

endmodule

@@ rtl/bfa_checker.sv @@
// Port-level checks of the frame allocator, bound to the top level.
// Depends on bfa_pkg and bitmap_frame_allocator_defines.svh.
`include "bitmap_frame_allocator_defines.svh"

module bfa_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [31:0] m_frame_address,
    input logic [15:0] m_total_frames,
    input logic [15:0] m_used_frames,
    input logic [15:0] m_free_frames,
    input logic [31:0] m_highest_end
);
    import bfa_pkg::*;

    `BFA_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_frame_address), "result beat changed while stalled")
    `BFA_ASSERT_NEXT(a_one_at_a_time, s_valid && s_ready, !s_ready, "second beat taken while busy")
    `BFA_ASSERT_NOW(a_free_math, m_valid, m_free_frames == ((m_used_frames < m_total_frames) ? m_total_frames - m_used_frames : 16'd0), "free count mismatch")
    `BFA_ASSERT_NOW(a_addr_ok, m_valid && (m_frame_address != 32'd0), (m_status == ST_OK) && (m_frame_address[11:0] == 12'd0), "bad allocated address")
    `BFA_ASSERT_NOW(a_not_ready, m_valid && (m_status == ST_NOT_READY), (m_total_frames == 16'd0) && (m_highest_end == 32'd0), "counters shown while not ready")

endmodule

bind bitmap_frame_allocator bfa_checker u_bfa_checker (
    .aclk            (aclk),
    .aresetn         (aresetn),
    .s_valid         (s_valid),
    .s_ready         (s_ready),
    .m_valid         (m_valid),
    .m_ready         (m_ready),
    .m_status        (m_status),
    .m_frame_address (m_frame_address),
    .m_total_frames  (m_total_frames),
    .m_used_frames   (m_used_frames),
    .m_free_frames   (m_free_frames),
    .m_highest_end   (m_highest_end)
);

@@ bench/bitmap_frame_allocator_test.sv @@
// Self-checking bench for bitmap_frame_allocator: directed and random beats,
// predicted results compared with every output beat. Needs only bfa_pkg and
// the allocator RTL.
`timescale 1ns / 100ps

module bitmap_frame_allocator_test;
    import bfa_pkg::*;

    localparam int NFRAMES = 32768;
    localparam int NSLOTS  = 8;
    localparam logic [63:0] PG_MASK = 64'hFFF;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_wr_en = 1'b0;
    logic [31:0] cfg_wr_data = '0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [2:0]  s_opcode = '0;
    logic [63:0] s_addr_a = '0;
    logic [63:0] s_addr_b = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_status;
    logic [31:0] m_frame_address;
    logic [15:0] m_total_frames;
    logic [15:0] m_used_frames;
    logic [15:0] m_free_frames;
    logic [31:0] m_highest_end;

    bitmap_frame_allocator u_top (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data),
        .s_valid(s_valid), .s_ready(s_ready), .s_opcode(s_opcode),
        .s_addr_a(s_addr_a), .s_addr_b(s_addr_b),
        .m_valid(m_valid), .m_ready(m_ready), .m_status(m_status),
        .m_frame_address(m_frame_address), .m_total_frames(m_total_frames),
        .m_used_frames(m_used_frames), .m_free_frames(m_free_frames),
        .m_highest_end(m_highest_end)
    );

    always #5 aclk = ~aclk;

    // allocator shadow state
    bit          frame_used [NFRAMES];
    logic [31:0] slot_lo [NSLOTS];
    logic [31:0] slot_hi [NSLOTS];
    int          slot_cnt;
    int          total_cnt;
    int          used_cnt;
    int          hint;
    logic [31:0] top_end;
    logic [31:0] kern_end;

    bfa_res_t    pending_results[$];
    logic [31:0] granted_frames[$];
    int          errors;
    bit          bursts;
    int          hold_cycles;

    task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
        $display("error: %s got %h expected %h at %0t", what, got, exp, $realtime);
        errors++;
    endtask

    function automatic bit in_any_slot(input logic [63:0] addr);
        for (int i = 0; i < slot_cnt; i++) begin
            if (addr >= {32'd0, slot_lo[i]} && addr < {32'd0, slot_hi[i]}) begin
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    function automatic void wipe_allocator();
        foreach (frame_used[i]) frame_used[i] = 1'b1;
        slot_cnt = 0;
        total_cnt = 0;
        used_cnt = 0;
        hint = 0;
        top_end = '0;
        granted_frames.delete();
    endfunction

    function automatic logic [2:0] add_slot(input logic [63:0] base, input logic [63:0] len);
        logic [63:0] lo, hi, floor_k;
        longint lim;
        lo = base;
        hi = base + len;
        if (hi < base) hi = '1;
        if (lo < LOW_LIMIT) lo = LOW_LIMIT;
        if (hi > TOP_LIMIT) hi = TOP_LIMIT;
        if (lo >= hi) return ST_REJECTED;
        lo = (lo + PG_MASK) & ~PG_MASK;
        hi = hi & ~PG_MASK;
        floor_k = ({32'd0, kern_end} + PG_MASK) & ~PG_MASK;
        if (lo < floor_k) lo = floor_k;
        if (lo >= hi || slot_cnt >= NSLOTS) return ST_REJECTED;
        slot_lo[slot_cnt] = lo[31:0];
        slot_hi[slot_cnt] = hi[31:0];
        slot_cnt++;
        if (hi[31:0] > top_end) top_end = hi[31:0];
        lim = longint'(hi >> 12);
        if (lim > NFRAMES) lim = NFRAMES;
        for (longint i = longint'(lo >> 12); i < lim; i++) begin
            if (frame_used[i]) begin
                frame_used[i] = 1'b0;
                if (total_cnt < 16'hFFFF) total_cnt++;
            end
        end
        return ST_OK;
    endfunction

    function automatic logic [2:0] reserve_span(input logic [63:0] lo, input logic [63:0] hi);
        logic [63:0] first, last;
        first = lo >> 12;
        last = (hi >> 12) + ((hi & PG_MASK) != 0 ? 64'd1 : 64'd0);
        if (slot_cnt == 0) return ST_NOT_READY;
        if (last > NFRAMES) last = NFRAMES;
        for (logic [63:0] i = first; i < last; i++) begin
            if (in_any_slot(i << 12) && !frame_used[i]) begin
                frame_used[i] = 1'b1;
                if (used_cnt < 16'hFFFF) used_cnt++;
            end
        end
        return ST_OK;
    endfunction

    function automatic logic [2:0] grab_frame(output logic [31:0] addr);
        int idx;
        addr = '0;
        if (slot_cnt == 0) return ST_NOT_READY;
        if (used_cnt >= total_cnt) return ST_NONE_FREE;
        idx = hint % NFRAMES;
        for (int n = 0; n < NFRAMES; n++) begin
            if (!frame_used[idx] && in_any_slot(64'(idx) << 12)) begin
                frame_used[idx] = 1'b1;
                hint = (idx + 1) % NFRAMES;
                if (used_cnt < 16'hFFFF) used_cnt++;
                addr = 32'(idx) << 12;
                return ST_OK;
            end
            idx = (idx + 1) % NFRAMES;
        end
        return ST_NONE_FREE;
    endfunction

    function automatic logic [2:0] release_frame(input logic [63:0] addr);
        logic [63:0] idx;
        if (slot_cnt == 0) return ST_NOT_READY;
        if ((addr & PG_MASK) != 0) return ST_MISALIGNED;
        idx = addr >> 12;
        if (idx >= NFRAMES || !in_any_slot(addr)) return ST_OUTSIDE;
        if (!frame_used[idx]) return ST_NOT_ALLOC;
        frame_used[idx] = 1'b0;
        if (int'(idx) < hint) hint = int'(idx);
        if (used_cnt > 0) used_cnt--;
        return ST_OK;
    endfunction

    function automatic bfa_res_t predict_result(input logic [2:0] op, input logic [63:0] a,
                                                input logic [63:0] b);
        bfa_res_t r;
        logic [31:0] fa;
        bit ready;
        r = '0;
        fa = '0;
        case (op)
            OP_CLEAR:   wipe_allocator();
            OP_ADD:     r.status = add_slot(a, b);
            OP_RESERVE: r.status = reserve_span(a, b);
            OP_ALLOC: begin
                r.status = grab_frame(fa);
                if (r.status == ST_OK) granted_frames.push_back(fa);
            end
            OP_FREE:    r.status = release_frame(a);
            default:    r.status = ST_OK;
        endcase
        ready = slot_cnt != 0;
        r.frame_address = fa;
        r.total_frames = ready ? 16'(total_cnt) : '0;
        r.used_frames = ready ? 16'(used_cnt) : '0;
        r.free_frames = (ready && used_cnt < total_cnt) ? 16'(total_cnt - used_cnt) : '0;
        r.highest_end = ready ? top_end : '0;
        return r;
    endfunction

    // Offer one beat; valid stays high on return so a following beat can
    // reuse it without a drop in between.
    task automatic send_op(input logic [2:0] op, input logic [63:0] a, input logic [63:0] b);
        if (bursts && $urandom_range(0, 5) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_opcode <= op;
        s_addr_a <= a;
        s_addr_b <= b;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_result(op, a, b));
    endtask

    task automatic drain();
        if (s_valid) s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
    endtask

    task automatic set_kernel_end(input logic [31:0] v);
        drain();
        repeat (10) @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        kern_end = v;
    endtask

    // receiver: random backpressure plus long hold-offs on request
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_cycles > 0) begin
                m_ready <= 1'b0;
                repeat (hold_cycles) @(posedge aclk);
                hold_cycles = 0;
            end else if (bursts && $urandom_range(0, 7) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    always @(posedge aclk) begin
        bfa_res_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                report("unexpected beat, status", 32'(m_status), 32'hX);
            end else begin
                e = pending_results.pop_front();
                if (m_status !== e.status) report("status", 32'(m_status), 32'(e.status));
                if (m_frame_address !== e.frame_address)
                    report("frame_address", m_frame_address, e.frame_address);
                if (m_total_frames !== e.total_frames)
                    report("total_frames", 32'(m_total_frames), 32'(e.total_frames));
                if (m_used_frames !== e.used_frames)
                    report("used_frames", 32'(m_used_frames), 32'(e.used_frames));
                if (m_free_frames !== e.free_frames)
                    report("free_frames", 32'(m_free_frames), 32'(e.free_frames));
                if (m_highest_end !== e.highest_end)
                    report("highest_end", m_highest_end, e.highest_end);
            end
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic test_directed();
        logic [31:0] fa;
        send_op(OP_ALLOC, '0, '0);
        send_op(OP_FREE, 64'h20_0000, '0);
        send_op(OP_RESERVE, '0, '1);
        send_op(3'd5, '1, '1);
        send_op(OP_ADD, '0, '0);
        send_op(OP_ADD, 64'h1_0000_0000, 64'h1000);
        // whole address space: clamps to 1 MiB .. 4 GiB with an all-ones end
        send_op(OP_ADD, '0, '1);
        send_op(OP_ALLOC, '0, '0);
        send_op(OP_FREE, 64'h0010_0004, '0);
        send_op(OP_FREE, 64'h1000_0000, '0);
        send_op(OP_FREE, '0, '0);
        send_op(OP_FREE, 64'h0020_0000, '0);
        send_op(OP_FREE, 64'h0010_0000, '0);
        send_op(OP_FREE, '1, '0);
        send_op(OP_RESERVE, '0, '1);
        send_op(OP_ALLOC, '0, '0);
        send_op(3'd6, '0, '0);
        send_op(3'd7, '1, '0);
        send_op(OP_CLEAR, '0, '0);
        for (int i = 0; i < 9; i++) begin
            send_op(OP_ADD, 64'h0010_0801 + 64'(i) * 64'h2_0000, 64'h1_1000);
        end
        drain();
    endtask

    task automatic test_kernel_end_limits();
        set_kernel_end('1);
        send_op(OP_CLEAR, '0, '0);
        send_op(OP_ADD, '0, '1);
        send_op(OP_ALLOC, '0, '0);
        set_kernel_end(32'h0034_5678);
        send_op(OP_ADD, '0, 64'h0040_0000);
        send_op(OP_ADD, 64'h0200_0000, 64'h0000_3000);
        send_op(OP_ALLOC, '0, '0);
        send_op(OP_ALLOC, '0, '0);
        set_kernel_end('0);
    endtask

    task automatic test_backpressure();
        hold_cycles = 400;
        for (int i = 0; i < 10; i++) send_op(OP_ALLOC, '0, '0);
        drain();
    endtask

    task automatic random_sequence();
        logic [63:0] a, b;
        int k;
        if ($urandom_range(0, 3) == 0) send_op(OP_CLEAR, '0, '0);
        repeat ($urandom_range(1, 4)) begin
            a = 64'($urandom_range(0, 32'h0900_0000));
            b = ($urandom_range(0, 9) == 0) ? 64'($urandom_range(0, 32'h0400_0000))
                                             : 64'($urandom_range(0, 32'h0004_0000));
            send_op(OP_ADD, a, b);
        end
        repeat ($urandom_range(20, 40)) begin
            case ($urandom_range(0, 9))
                0: begin
                    a = 64'($urandom_range(0, 32'h0810_0000));
                    send_op(OP_RESERVE, a, a + 64'($urandom_range(0, 32'h8000)));
                end
                1, 2, 3, 4: send_op(OP_ALLOC, rand64(), rand64());
                5, 6: begin
                    if (granted_frames.size() != 0) begin
                        k = $urandom_range(0, granted_frames.size() - 1);
                        a = {32'd0, granted_frames[k]};
                        granted_frames.delete(k);
                    end else begin
                        a = 64'($urandom_range(0, 32'h0800_0000)) & ~PG_MASK;
                    end
                    send_op(OP_FREE, a, rand64());
                end
                7: send_op(OP_FREE, 64'($urandom_range(0, 32'h0900_0000)) & ~PG_MASK, '0);
                default: send_op(3'($urandom_range(0, 7)), rand64(), rand64());
            endcase
        end
    endtask

    task automatic test_random();
        int sent;
        sent = 0;
        bursts = 1'b1;
        while (sent < 900) begin
            if ($urandom_range(0, 5) == 0) begin
                set_kernel_end(($urandom_range(0, 7) == 0) ? $urandom()
                                                           : $urandom_range(0, 32'h0200_0000));
            end
            random_sequence();
            sent += 33;
        end
        // finish with no idling on either side
        drain();
        bursts = 1'b0;
        repeat (6) random_sequence();
        drain();
    endtask

    initial begin
        errors = 0;
        bursts = 1'b0;
        hold_cycles = 0;
        kern_end = '0;
        wipe_allocator();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_kernel_end_limits();
        bursts = 1'b1;
        test_backpressure();
        test_random();
        repeat (100) @(posedge aclk);
        if (errors == 0) begin
            $display("bitmap_frame_allocator: match");
        end else begin
            $display("bitmap_frame_allocator: mismatch");
        end
        $finish;
    end

    initial begin
        #100_000_000;
        $display("bitmap_frame_allocator: mismatch");
        $finish;
    end
endmodule

@@ filelist.f @@
+incdir+rtl
rtl/bfa_pkg.sv
rtl/bfa_ctrl.sv
rtl/bfa_datapath.sv
rtl/bitmap_frame_allocator.sv
rtl/bfa_checker.sv
bench/bitmap_frame_allocator_test.sv
